@@ src/awm_pkg.sv @@
// Shared types, widths and register codes for the ADC window level meter.
package awm_pkg;

  localparam int ADC_BITS   = 12;
  localparam int COUNT_BITS = 16;
  localparam int SUM_BITS   = ADC_BITS + COUNT_BITS;
  localparam int SPAN_BITS  = 13;
  localparam int STEP_BITS  = $clog2(ADC_BITS);
  localparam int QPTR_BITS  = 2;
  localparam int QDEPTH     = 2 ** QPTR_BITS;
  localparam int ADDR_BITS  = 5;
  localparam int DATA_BITS  = 32;

  localparam logic [2:0] REG_CLIP_LOW  = 3'd0;
  localparam logic [2:0] REG_CLIP_HIGH = 3'd1;
  localparam logic [2:0] REG_LOW_SPAN  = 3'd2;
  localparam logic [2:0] REG_GOOD_SPAN = 3'd3;
  localparam logic [2:0] REG_HIGH_SPAN = 3'd4;

  typedef enum logic [1:0] {
    LVL_LOW  = 2'd0,
    LVL_GOOD = 2'd1,
    LVL_HIGH = 2'd2,
    LVL_CLIP = 2'd3
  } level_t;

  // One closed window as handed from the accumulator to the result stage.
  typedef struct packed {
    logic [ADC_BITS-1:0]   min_code;
    logic [ADC_BITS-1:0]   max_code;
    logic [SUM_BITS-1:0]   sum;
    logic [COUNT_BITS-1:0] count;
  } window_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic [ADC_BITS-1:0]  clip_low;
    logic [ADC_BITS-1:0]  clip_high;
    logic [SPAN_BITS-1:0] low_span;
    logic [SPAN_BITS-1:0] good_span;
    logic [SPAN_BITS-1:0] high_span;
  } cfg_t;

endpackage

@@ src/awm_front.sv @@
// Window accumulator: tracks min, max, sum and count and closes a window on the last beat.
module awm_front import awm_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [ADC_BITS-1:0] in_sample_code,
  input  logic                in_window_last,
  input  q_stat_t             q_stat,
  output logic                q_push,
  output window_rec_t         q_wdata
);

  logic [ADC_BITS-1:0]   min_r, min_nxt;
  logic [ADC_BITS-1:0]   max_r, max_nxt;
  logic [SUM_BITS-1:0]   sum_r, sum_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                  accept;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = accept && in_window_last;

  always_comb begin
    min_nxt = (in_sample_code < min_r) ? in_sample_code : min_r;
    max_nxt = (in_sample_code > max_r) ? in_sample_code : max_r;
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    // Sum and count freeze at the count bound; min and max keep tracking.
    if (cnt_r != {COUNT_BITS{1'b1}}) begin
      sum_nxt = sum_r + SUM_BITS'(in_sample_code);
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  assign q_wdata = '{min_code: min_nxt, max_code: max_nxt, sum: sum_nxt, count: cnt_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= {ADC_BITS{1'b1}};
      max_r <= '0;
      sum_r <= '0;
      cnt_r <= '0;
    end else if (accept) begin
      if (in_window_last) begin
        min_r <= {ADC_BITS{1'b1}};
        max_r <= '0;
        sum_r <= '0;
        cnt_r <= '0;
      end else begin
        min_r <= min_nxt;
        max_r <= max_nxt;
        sum_r <= sum_nxt;
        cnt_r <= cnt_nxt;
      end
    end
  end

endmodule

@@ src/awm_queue.sv @@
// Small queue of closed windows between the accumulator and the result stage.
module awm_queue import awm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  window_rec_t wdata,
  input  logic        pop,
  output window_rec_t rdata,
  output q_stat_t     stat
);

  window_rec_t          mem_r [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r;
  logic [QPTR_BITS-1:0] rd_ptr_r;
  logic [QPTR_BITS:0]   fill_r;

  assign stat.full  = (fill_r == (QPTR_BITS+1)'(QDEPTH));
  assign stat.empty = (fill_r == '0);
  assign rdata      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   fill_r <= fill_r + 1'b1;
        2'b01:   fill_r <= fill_r - 1'b1;
        default: fill_r <= fill_r;
      endcase
    end
  end

endmodule

@@ src/awm_back.sv @@
// Result stage: serial average division, span, level grading and the output register.
module awm_back import awm_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  cfg_t                cfg,
  input  q_stat_t             q_stat,
  input  window_rec_t         q_rdata,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [ADC_BITS-1:0] out_min_code,
  output logic [ADC_BITS-1:0] out_max_code,
  output logic [ADC_BITS-1:0] out_avg_code,
  output logic [ADC_BITS-1:0] out_span_code,
  output logic [1:0]          out_level_status
);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_OUT} state_t;

  state_t                state_r;
  logic                  out_valid_r;
  logic [ADC_BITS-1:0]   min_r, max_r, span_r;
  level_t                lvl_r;
  logic [COUNT_BITS-1:0] div_r;
  logic [COUNT_BITS-1:0] rem_r, rem_nxt;
  logic [ADC_BITS-1:0]   quo_r, quo_nxt;
  logic [STEP_BITS-1:0]  step_r;
  logic [ADC_BITS-1:0]   omin_r, omax_r, oavg_r, ospan_r;
  level_t                olvl_r;

  logic [ADC_BITS-1:0]   span_nxt;
  logic [SPAN_BITS-1:0]  span_ext;
  level_t                lvl_nxt;
  logic [COUNT_BITS:0]   trial;
  logic                  fits;
  logic                  out_load;

  assign q_pop    = (state_r == S_IDLE) && !q_stat.empty;
  assign out_load = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  always_comb begin
    span_nxt = (q_rdata.max_code >= q_rdata.min_code) ?
               (q_rdata.max_code - q_rdata.min_code) : '0;
    span_ext = SPAN_BITS'(span_nxt);
    if (q_rdata.min_code < cfg.clip_low || q_rdata.max_code > cfg.clip_high) begin
      lvl_nxt = LVL_CLIP;
    end else if (span_ext < cfg.low_span) begin
      lvl_nxt = LVL_LOW;
    end else if (span_ext < cfg.good_span) begin
      lvl_nxt = LVL_GOOD;
    end else if (span_ext < cfg.high_span) begin
      lvl_nxt = LVL_HIGH;
    end else begin
      lvl_nxt = LVL_CLIP;
    end
  end

  // One restoring division step: the quotient fits ADC_BITS since the
  // average never exceeds the largest sample.
  always_comb begin
    trial   = {rem_r, quo_r[ADC_BITS-1]} - {1'b0, div_r};
    fits    = ({rem_r, quo_r[ADC_BITS-1]} >= {1'b0, div_r});
    rem_nxt = fits ? trial[COUNT_BITS-1:0] : {rem_r[COUNT_BITS-2:0], quo_r[ADC_BITS-1]};
    quo_nxt = {quo_r[ADC_BITS-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (!q_stat.empty) begin
            min_r   <= q_rdata.min_code;
            max_r   <= q_rdata.max_code;
            span_r  <= span_nxt;
            lvl_r   <= lvl_nxt;
            div_r   <= q_rdata.count;
            rem_r   <= q_rdata.sum[SUM_BITS-1:ADC_BITS];
            quo_r   <= q_rdata.sum[ADC_BITS-1:0];
            step_r  <= '0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          rem_r  <= rem_nxt;
          quo_r  <= quo_nxt;
          step_r <= step_r + 1'b1;
          if (step_r == STEP_BITS'(ADC_BITS - 1)) state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            omin_r  <= min_r;
            omax_r  <= max_r;
            oavg_r  <= quo_r;
            ospan_r <= span_r;
            olvl_r  <= lvl_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_min_code     = omin_r;
  assign out_max_code     = omax_r;
  assign out_avg_code     = oavg_r;
  assign out_span_code    = ospan_r;
  assign out_level_status = olvl_r;

endmodule

@@ src/adc_window_level_meter.sv @@
// Top level of the ADC window level meter: register port, accumulator, queue and result stage.
//
// Input channel: one 12-bit sample per beat with a last-of-window flag. The
// accumulator takes a beat every cycle while the window queue has room.
// On the flagged beat the window (min, max, sum, count) moves into a
// four-entry queue and the accumulators clear in the same cycle.
// Result channel: one beat per window with min, max, floor average, span and
// level status (0 low, 1 good, 2 high, 3 clip).
// The result stage takes one window at a time from the queue: it pops the
// window while idle, runs the 12-step serial divider that forms the average
// and then loads the output register, so windows that arrive faster than it
// finishes them fill the queue and then stall the input until results drain.
// When out_stall is high the result is held in the output register; the
// divider finishes the next window and waits, and the queue keeps absorbing.
// Reset (rst_n low, synchronous) clears the accumulators, the queue and the
// output valid and loads the threshold registers with their defaults.
// Registers sit at byte addresses 0, 4, 8, 12 and 16 on the APB port;
// writes are meant to happen only while no window is in flight.
module adc_window_level_meter import awm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [ADC_BITS-1:0]  in_sample_code,
  input  logic                 in_window_last,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [ADC_BITS-1:0]  out_min_code,
  output logic [ADC_BITS-1:0]  out_max_code,
  output logic [ADC_BITS-1:0]  out_avg_code,
  output logic [ADC_BITS-1:0]  out_span_code,
  output logic [1:0]           out_level_status
);

  cfg_t        cfg_r;
  logic        wr_en;
  logic [2:0]  reg_idx;
  q_stat_t     q_stat;
  logic        q_push;
  logic        q_pop;
  window_rec_t q_wdata;
  window_rec_t q_rdata;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_BITS-1:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.clip_low  <= ADC_BITS'(41);
      cfg_r.clip_high <= ADC_BITS'(4054);
      cfg_r.low_span  <= SPAN_BITS'(310);
      cfg_r.good_span <= SPAN_BITS'(2482);
      cfg_r.high_span <= SPAN_BITS'(3723);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_CLIP_LOW:  cfg_r.clip_low  <= pwdata[ADC_BITS-1:0];
        REG_CLIP_HIGH: cfg_r.clip_high <= pwdata[ADC_BITS-1:0];
        REG_LOW_SPAN:  cfg_r.low_span  <= pwdata[SPAN_BITS-1:0];
        REG_GOOD_SPAN: cfg_r.good_span <= pwdata[SPAN_BITS-1:0];
        REG_HIGH_SPAN: cfg_r.high_span <= pwdata[SPAN_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CLIP_LOW:  prdata = DATA_BITS'(cfg_r.clip_low);
      REG_CLIP_HIGH: prdata = DATA_BITS'(cfg_r.clip_high);
      REG_LOW_SPAN:  prdata = DATA_BITS'(cfg_r.low_span);
      REG_GOOD_SPAN: prdata = DATA_BITS'(cfg_r.good_span);
      REG_HIGH_SPAN: prdata = DATA_BITS'(cfg_r.high_span);
      default:       prdata = '0;
    endcase
  end

  awm_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample_code (in_sample_code),
    .in_window_last (in_window_last),
    .q_stat         (q_stat),
    .q_push         (q_push),
    .q_wdata        (q_wdata)
  );

  awm_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  awm_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_stat           (q_stat),
    .q_rdata          (q_rdata),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_min_code     (out_min_code),
    .out_max_code     (out_max_code),
    .out_avg_code     (out_avg_code),
    .out_span_code    (out_span_code),
    .out_level_status (out_level_status)
  );

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full) else $error("window pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty) else $error("window popped from an empty queue");

  a_avg_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_avg_code >= out_min_code) && (out_avg_code <= out_max_code))
    else $error("average outside the min/max range");

  a_span_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_span_code == out_max_code - out_min_code))
    else $error("span does not equal max minus min");
`endif

endmodule
